### src/epoch_seconds_to_calendar_macros.svh
// Assertion macros for the epoch-to-calendar RTL.
`ifndef EPOCH_SECONDS_TO_CALENDAR_MACROS_SVH
`define EPOCH_SECONDS_TO_CALENDAR_MACROS_SVH

`ifndef SYNTHESIS
// Property checked on clk, disabled while rst_n is low
`define ESC_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
// Condition that must never be true on a clock edge
`define ESC_ASSERT_NEVER(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);
`else
`define ESC_ASSERT(name, prop, msg)
`define ESC_ASSERT_NEVER(name, cond, msg)
`endif

`endif

### src/esc_pkg.sv
// Types, constants and tables for the epoch-to-calendar converter.
`timescale 1ns / 1ps
`default_nettype none

package esc_pkg;

    // Field widths
    localparam int EPOCH_W = 31;
    localparam int SEC_W   = 6;
    localparam int MIN_W   = 6;
    localparam int HOUR_W  = 5;
    localparam int WDAY_W  = 3;
    localparam int YEAR_W  = 8;
    localparam int MON_W   = 4;
    localparam int DOM_W   = 5;

    // Shared constant divider: quotient width covers the day count
    localparam int QUO_W      = 15;
    localparam int CNT_W      = 2;
    localparam int DIV_CYCLES = 2;   // quotient cycle, then remainder cycle

    localparam int SECS_PER_DAY  = 86400;
    localparam int SECS_PER_HOUR = 3600;
    localparam int SECS_PER_MIN  = 60;
    localparam int DAYS_PER_WEEK = 7;
    localparam int EPOCH_WDAY    = 4;   // day 0 was a Thursday

    // Divisors for the remainder multiply
    localparam logic [16:0] DIVISOR_DAY  = 17'(SECS_PER_DAY);
    localparam logic [16:0] DIVISOR_HOUR = 17'(SECS_PER_HOUR);
    localparam logic [16:0] DIVISOR_MIN  = 17'(SECS_PER_MIN);
    localparam logic [16:0] DIVISOR_WDAY = 17'(DAYS_PER_WEEK);

    // Reciprocals: (n * RECIP) >> shift is exact over each operand range
    //   day:  n = secs >> 7  (24 bits), divide by 675, shift 34
    //   hour: n = tod >> 4   (13 bits), divide by 225, shift 21
    //   min:  n = rest >> 2  (10 bits), divide by 15,  shift 14
    //   wday: n = days + 4   (15 bits), divide by 7,   shift 18
    localparam logic [24:0] RECIP_DAY  = 25'd25451659;
    localparam logic [24:0] RECIP_HOUR = 25'd9321;
    localparam logic [24:0] RECIP_MIN  = 25'd1093;
    localparam logic [24:0] RECIP_WDAY = 25'd37450;

    // Year counters start at 1970
    localparam logic [YEAR_W-1:0] YEAR_INIT = YEAR_W'(70);
    localparam logic [1:0]        Y4_INIT   = 2'd2;
    localparam logic [6:0]        Y100_INIT = 7'd70;
    localparam logic [8:0]        Y400_INIT = 9'd370;
    localparam logic [6:0]        Y100_LAST = 7'd99;
    localparam logic [8:0]        Y400_LAST = 9'd399;

    localparam logic [8:0] DAYS_LEAP_YEAR   = 9'd366;
    localparam logic [8:0] DAYS_COMMON_YEAR = 9'd365;
    localparam logic [MON_W-1:0] MONTH_JAN = 4'd0;
    localparam logic [MON_W-1:0] MONTH_FEB = 4'd1;
    localparam logic [MON_W-1:0] MONTH_DEC = 4'd11;

    typedef enum logic [1:0] {
        DIV_DAY  = 2'd0,
        DIV_HOUR = 2'd1,
        DIV_MIN  = 2'd2,
        DIV_WDAY = 2'd3
    } div_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic     start;
        logic     div_quo;
        logic     div_rem;
        div_sel_t div_sel;
        logic     save_days;
        logic     save_hour;
        logic     save_min;
        logic     save_wday;
        logic     load_wday;
        logic     load_days;
        logic     year_step;
        logic     month_step;
        logic     publish;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic year_fits;
        logic month_last;
    } dp_stat_t;

    // Month length, February follows the leap flag
    function automatic logic [4:0] month_days(input logic [MON_W-1:0] m, input logic leap);
        logic [4:0] d;
        case (m)
            4'd0:    d = 5'd31;
            4'd1:    d = leap ? 5'd29 : 5'd28;
            4'd2:    d = 5'd31;
            4'd3:    d = 5'd30;
            4'd4:    d = 5'd31;
            4'd5:    d = 5'd30;
            4'd6:    d = 5'd31;
            4'd7:    d = 5'd31;
            4'd8:    d = 5'd30;
            4'd9:    d = 5'd31;
            4'd10:   d = 5'd30;
            4'd11:   d = 5'd31;
            default: d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

### src/esc_ifs.sv
// Valid/ready channel interfaces for request and response transactions.
`timescale 1ns / 1ps
`default_nettype none

interface esc_req_if import esc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [EPOCH_W-1:0] epoch_seconds;

    modport source (output valid, output epoch_seconds, input ready);
    modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface esc_rsp_if import esc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [SEC_W-1:0]  second;
    logic [MIN_W-1:0]  minute;
    logic [HOUR_W-1:0] hour;
    logic [WDAY_W-1:0] weekday;
    logic [YEAR_W-1:0] years_since_1900;
    logic [MON_W-1:0]  month_index;
    logic [DOM_W-1:0]  day_of_month;

    modport source (output valid, output second, output minute, output hour,
                    output weekday, output years_since_1900, output month_index,
                    output day_of_month, input ready);
    modport sink   (input valid, input second, input minute, input hour,
                    input weekday, input years_since_1900, input month_index,
                    input day_of_month, output ready);
endinterface

`default_nettype wire

### src/esc_datapath.sv
// Datapath: reciprocal-multiply divider, year and month subtract loops, result registers.
`timescale 1ns / 1ps
`default_nettype none

module esc_datapath import esc_pkg::*; (
    input  wire logic               clk,
    input  wire dp_cmd_t            cmd,
    input  wire logic [EPOCH_W-1:0] epoch_seconds,
    output dp_stat_t                stat,
    output logic [SEC_W-1:0]        second,
    output logic [MIN_W-1:0]        minute,
    output logic [HOUR_W-1:0]       hour,
    output logic [WDAY_W-1:0]       weekday,
    output logic [YEAR_W-1:0]       years_since_1900,
    output logic [MON_W-1:0]        month_index,
    output logic [DOM_W-1:0]        day_of_month
);

    // Working registers
    logic [EPOCH_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0]   quo_reg, quo_next;
    logic [QUO_W-1:0]   days_reg, days_next;
    logic [SEC_W-1:0]   sec_reg, sec_next;
    logic [MIN_W-1:0]   min_reg, min_next;
    logic [HOUR_W-1:0]  hour_reg, hour_next;
    logic [WDAY_W-1:0]  wday_reg, wday_next;
    logic [YEAR_W-1:0]  year_reg, year_next;
    logic [1:0]         y4_reg, y4_next;
    logic [6:0]         y100_reg, y100_next;
    logic [8:0]         y400_reg, y400_next;
    logic [MON_W-1:0]   mon_reg, mon_next;

    // Result holding registers
    logic [SEC_W-1:0]   o_sec_reg, o_sec_next;
    logic [MIN_W-1:0]   o_min_reg, o_min_next;
    logic [HOUR_W-1:0]  o_hour_reg, o_hour_next;
    logic [WDAY_W-1:0]  o_wday_reg, o_wday_next;
    logic [YEAR_W-1:0]  o_year_reg, o_year_next;
    logic [MON_W-1:0]   o_mon_reg, o_mon_next;
    logic [DOM_W-1:0]   o_dom_reg, o_dom_next;

    logic [23:0]        mul_a;
    logic [24:0]        mul_b;
    logic [48:0]        mul_p;
    logic [QUO_W-1:0]   quo_calc;
    logic [16:0]        div_d;
    logic [31:0]        qd_prod;
    logic [EPOCH_W-1:0] rem_sub;
    logic               leap;
    logic [8:0]         ylen;
    logic [4:0]         mlen;
    logic [EPOCH_W-1:0] days_ext;

    // Operand, reciprocal and divisor for the selected division
    always_comb
    begin
        case (cmd.div_sel)
            DIV_DAY:
            begin
                mul_a = rem_reg[EPOCH_W-1:7];
                mul_b = RECIP_DAY;
                div_d = DIVISOR_DAY;
            end
            DIV_HOUR:
            begin
                mul_a = {11'd0, rem_reg[16:4]};
                mul_b = RECIP_HOUR;
                div_d = DIVISOR_HOUR;
            end
            DIV_MIN:
            begin
                mul_a = {14'd0, rem_reg[11:2]};
                mul_b = RECIP_MIN;
                div_d = DIVISOR_MIN;
            end
            DIV_WDAY:
            begin
                mul_a = {9'd0, rem_reg[14:0]};
                mul_b = RECIP_WDAY;
                div_d = DIVISOR_WDAY;
            end
            default:
            begin
                mul_a = rem_reg[EPOCH_W-1:7];
                mul_b = RECIP_DAY;
                div_d = DIVISOR_DAY;
            end
        endcase
    end

    assign mul_p = {25'd0, mul_a} * {24'd0, mul_b};

    // Quotient is the product shifted by the reciprocal's scale
    always_comb
    begin
        case (cmd.div_sel)
            DIV_DAY:  quo_calc = mul_p[48:34];
            DIV_HOUR: quo_calc = mul_p[35:21];
            DIV_MIN:  quo_calc = mul_p[28:14];
            DIV_WDAY: quo_calc = mul_p[32:18];
            default:  quo_calc = mul_p[48:34];
        endcase
    end

    // Remainder from the registered quotient
    assign qd_prod  = {17'd0, quo_reg} * {15'd0, div_d};
    assign rem_sub  = rem_reg - qd_prod[EPOCH_W-1:0];
    assign days_ext = {{(EPOCH_W - QUO_W){1'b0}}, days_reg};

    // Gregorian leap rule from the running residues
    assign leap = (y4_reg == 2'd0) && ((y100_reg != 7'd0) || (y400_reg == 9'd0));
    assign ylen = leap ? DAYS_LEAP_YEAR : DAYS_COMMON_YEAR;
    assign mlen = month_days(mon_reg, leap);

    assign stat.year_fits  = (rem_reg < {{(EPOCH_W - 9){1'b0}}, ylen});
    assign stat.month_last = (mon_reg == MONTH_DEC) ||
                             (rem_reg < {{(EPOCH_W - 5){1'b0}}, mlen});

    // Next-state logic
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        days_next = days_reg;
        sec_next  = sec_reg;
        min_next  = min_reg;
        hour_next = hour_reg;
        wday_next = wday_reg;
        year_next = year_reg;
        y4_next   = y4_reg;
        y100_next = y100_reg;
        y400_next = y400_reg;
        mon_next  = mon_reg;
        o_sec_next  = o_sec_reg;
        o_min_next  = o_min_reg;
        o_hour_next = o_hour_reg;
        o_wday_next = o_wday_reg;
        o_year_next = o_year_reg;
        o_mon_next  = o_mon_reg;
        o_dom_next  = o_dom_reg;

        if (cmd.div_quo)
            quo_next = quo_calc;

        if (cmd.div_rem)
            rem_next = rem_sub;

        if (cmd.start)
        begin
            rem_next  = epoch_seconds;
            year_next = YEAR_INIT;
            y4_next   = Y4_INIT;
            y100_next = Y100_INIT;
            y400_next = Y400_INIT;
            mon_next  = MONTH_JAN;
        end

        // Remainder-cycle captures
        if (cmd.save_days)
            days_next = quo_reg;
        if (cmd.save_hour)
            hour_next = quo_reg[HOUR_W-1:0];
        if (cmd.save_min)
        begin
            min_next = quo_reg[MIN_W-1:0];
            sec_next = rem_sub[SEC_W-1:0];
        end
        if (cmd.save_wday)
            wday_next = rem_sub[WDAY_W-1:0];

        // Weekday division starts from days + 4
        if (cmd.load_wday)
            rem_next = days_ext + EPOCH_W'(EPOCH_WDAY);

        if (cmd.load_days)
            rem_next = days_ext;

        // Whole-year subtraction
        if (cmd.year_step)
        begin
            rem_next  = rem_reg - {{(EPOCH_W - 9){1'b0}}, ylen};
            year_next = year_reg + YEAR_W'(1);
            y4_next   = y4_reg + 2'd1;
            y100_next = (y100_reg == Y100_LAST) ? 7'd0 : (y100_reg + 7'd1);
            y400_next = (y400_reg == Y400_LAST) ? 9'd0 : (y400_reg + 9'd1);
        end

        // Month subtraction
        if (cmd.month_step)
        begin
            rem_next = rem_reg - {{(EPOCH_W - 5){1'b0}}, mlen};
            mon_next = mon_reg + MON_W'(1);
        end

        // Hand the finished transaction to the output registers
        if (cmd.publish)
        begin
            o_sec_next  = sec_reg;
            o_min_next  = min_reg;
            o_hour_next = hour_reg;
            o_wday_next = wday_reg;
            o_year_next = year_reg;
            o_mon_next  = mon_reg;
            o_dom_next  = rem_reg[DOM_W-1:0] + DOM_W'(1);
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        days_reg   <= days_next;
        sec_reg    <= sec_next;
        min_reg    <= min_next;
        hour_reg   <= hour_next;
        wday_reg   <= wday_next;
        year_reg   <= year_next;
        y4_reg     <= y4_next;
        y100_reg   <= y100_next;
        y400_reg   <= y400_next;
        mon_reg    <= mon_next;
        o_sec_reg  <= o_sec_next;
        o_min_reg  <= o_min_next;
        o_hour_reg <= o_hour_next;
        o_wday_reg <= o_wday_next;
        o_year_reg <= o_year_next;
        o_mon_reg  <= o_mon_next;
        o_dom_reg  <= o_dom_next;
    end

    assign second           = o_sec_reg;
    assign minute           = o_min_reg;
    assign hour             = o_hour_reg;
    assign weekday          = o_wday_reg;
    assign years_since_1900 = o_year_reg;
    assign month_index      = o_mon_reg;
    assign day_of_month     = o_dom_reg;

endmodule

`default_nettype wire

### src/esc_ctrl.sv
// Controller: sequences divisions, year and month loops, and the handshakes.
`timescale 1ns / 1ps
`default_nettype none

`include "epoch_seconds_to_calendar_macros.svh"

module esc_ctrl import esc_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_ready,
    output logic          rsp_valid,
    input  wire logic     rsp_ready,
    output dp_cmd_t       cmd,
    input  wire dp_stat_t stat
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_DAY   = 8'b0000_0010,
        S_HOUR  = 8'b0000_0100,
        S_MIN   = 8'b0000_1000,
        S_WDAY  = 8'b0001_0000,
        S_YEAR  = 8'b0010_0000,
        S_MONTH = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             vld_reg, vld_next;
    logic             last;
    logic             out_free;

    assign last      = (cnt_reg == '0);
    assign out_free  = !vld_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = vld_reg;

    // Sequencer: each division is a quotient cycle then a remainder cycle
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.div_sel = DIV_DAY;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.start  = 1'b1;
                    cnt_next   = CNT_W'(DIV_CYCLES - 1);
                    state_next = S_DAY;
                end
            end
            S_DAY:
            begin
                cmd.div_sel = DIV_DAY;
                if (!last)
                begin
                    cmd.div_quo = 1'b1;
                    cnt_next    = cnt_reg - CNT_W'(1);
                end
                else
                begin
                    cmd.div_rem   = 1'b1;
                    cmd.save_days = 1'b1;
                    cnt_next      = CNT_W'(DIV_CYCLES - 1);
                    state_next    = S_HOUR;
                end
            end
            S_HOUR:
            begin
                cmd.div_sel = DIV_HOUR;
                if (!last)
                begin
                    cmd.div_quo = 1'b1;
                    cnt_next    = cnt_reg - CNT_W'(1);
                end
                else
                begin
                    cmd.div_rem   = 1'b1;
                    cmd.save_hour = 1'b1;
                    cnt_next      = CNT_W'(DIV_CYCLES - 1);
                    state_next    = S_MIN;
                end
            end
            S_MIN:
            begin
                cmd.div_sel = DIV_MIN;
                if (!last)
                begin
                    cmd.div_quo = 1'b1;
                    cnt_next    = cnt_reg - CNT_W'(1);
                end
                else
                begin
                    cmd.save_min  = 1'b1;
                    cmd.load_wday = 1'b1;
                    cnt_next      = CNT_W'(DIV_CYCLES - 1);
                    state_next    = S_WDAY;
                end
            end
            S_WDAY:
            begin
                cmd.div_sel = DIV_WDAY;
                if (!last)
                begin
                    cmd.div_quo = 1'b1;
                    cnt_next    = cnt_reg - CNT_W'(1);
                end
                else
                begin
                    cmd.save_wday = 1'b1;
                    cmd.load_days = 1'b1;
                    state_next    = S_YEAR;
                end
            end
            S_YEAR:
            begin
                if (stat.year_fits)
                    state_next = S_MONTH;
                else
                    cmd.year_step = 1'b1;
            end
            S_MONTH:
            begin
                if (stat.month_last)
                    state_next = S_DONE;
                else
                    cmd.month_step = 1'b1;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid: set on publish, cleared when the transaction is taken
    always_comb
    begin
        vld_next = vld_reg;
        if (cmd.publish)
            vld_next = 1'b1;
        else if (rsp_ready)
            vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            vld_reg   <= vld_next;
        end
    end

    // Checks
    `ESC_ASSERT(a_accept_starts_day, (state_reg == S_IDLE && req_valid) |=> (state_reg == S_DAY), "accepted transaction did not start the day division")
    `ESC_ASSERT(a_done_waits, (state_reg == S_DONE && vld_reg && !rsp_ready) |=> (state_reg == S_DONE), "result overwritten while output still pending")
    `ESC_ASSERT_NEVER(a_year_step_fits, cmd.year_step && stat.year_fits, "year subtracted although remaining days fit")
    `ESC_ASSERT(a_hour_cnt, (state_reg == S_HOUR) |-> (cnt_reg < CNT_W'(DIV_CYCLES)), "hour division step count out of range")

endmodule

`default_nettype wire

### src/epoch_seconds_to_calendar.sv
// From an accepted request to response valid, four reciprocal-multiply divisions run
// (each a quotient step then a remainder step), then one year-subtract step per whole
// year after 1970 and one month-subtract step per whole month in the final year.
// A request is taken only in idle, once the previous result is published; the next
// is accepted while a result waits. Reset (rst_n, async, active low) idles the
// controller and drops response valid.
`timescale 1ns / 1ps
`default_nettype none

module epoch_seconds_to_calendar import esc_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    esc_req_if.sink   req,
    esc_rsp_if.source rsp
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequencer
    esc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // Arithmetic and result registers
    esc_datapath u_dp (
        .clk              (clk),
        .cmd              (cmd),
        .epoch_seconds    (req.epoch_seconds),
        .stat             (stat),
        .second           (rsp.second),
        .minute           (rsp.minute),
        .hour             (rsp.hour),
        .weekday          (rsp.weekday),
        .years_since_1900 (rsp.years_since_1900),
        .month_index      (rsp.month_index),
        .day_of_month     (rsp.day_of_month)
    );

endmodule

`default_nettype wire

### dv/tb.sv
// Self-checking testbench for the epoch-seconds to calendar converter.
`timescale 1ns / 1ps

module tb;
    import esc_pkg::*;

    localparam int RANDOM_ITEMS  = 850;
    localparam int QUIET_LIMIT   = 4000;
    localparam int DRAIN_CYCLES  = 130;
    localparam int MAX_DAY_INDEX = 24855;

    // Expected broken-down time for one transaction
    typedef struct packed {
        logic [SEC_W-1:0]  second;
        logic [MIN_W-1:0]  minute;
        logic [HOUR_W-1:0] hour;
        logic [WDAY_W-1:0] weekday;
        logic [YEAR_W-1:0] years_since_1900;
        logic [MON_W-1:0]  month_index;
        logic [DOM_W-1:0]  day_of_month;
    } calendar_t;

    // Holds the dates predicted for accepted requests and checks responses
    class calendar_checker;
        calendar_t   pending_dates[$];
        int unsigned errors;

        function new();
            errors = 0;
        endfunction

        static function bit leap_year(int unsigned y);
            return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
        endfunction

        static function int unsigned days_in_month(int unsigned m, bit leap);
            int unsigned lengths[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
            if (m == 1 && leap)
                return 29;
            return lengths[m];
        endfunction

        // Split seconds into time of day, weekday, then peel whole years and months
        static function calendar_t to_calendar(logic [EPOCH_W-1:0] secs);
            calendar_t   c;
            int unsigned total;
            int unsigned tod;
            int unsigned day_count;
            int unsigned yr;
            int unsigned mon;
            bit          leap;
            total     = secs;
            tod       = total % 86400;
            day_count = total / 86400;
            c.second  = SEC_W'(tod % 60);
            c.minute  = MIN_W'((tod % 3600) / 60);
            c.hour    = HOUR_W'(tod / 3600);
            c.weekday = WDAY_W'((day_count + 4) % 7);
            yr = 1970;
            while (day_count >= (leap_year(yr) ? 366 : 365)) begin
                day_count -= leap_year(yr) ? 366 : 365;
                yr++;
            end
            leap = leap_year(yr);
            mon  = 0;
            while (mon < 11 && day_count >= days_in_month(mon, leap)) begin
                day_count -= days_in_month(mon, leap);
                mon++;
            end
            c.years_since_1900 = YEAR_W'(yr - 1900);
            c.month_index      = MON_W'(mon);
            c.day_of_month     = DOM_W'(day_count + 1);
            return c;
        endfunction

        function void note_request(logic [EPOCH_W-1:0] secs);
            pending_dates.push_back(to_calendar(secs));
        endfunction

        function void check_field(string name, int unsigned exp, int unsigned act);
            if (exp != act) begin
                $error("%s mismatch: expected %0d, actual %0d", name, exp, act);
                errors++;
            end
        endfunction

        function void check_result(calendar_t got);
            calendar_t exp;
            if (pending_dates.size() == 0) begin
                $error("response with no request outstanding");
                errors++;
                return;
            end
            exp = pending_dates.pop_front();
            check_field("second", exp.second, got.second);
            check_field("minute", exp.minute, got.minute);
            check_field("hour", exp.hour, got.hour);
            check_field("weekday", exp.weekday, got.weekday);
            check_field("years_since_1900", exp.years_since_1900, got.years_since_1900);
            check_field("month_index", exp.month_index, got.month_index);
            check_field("day_of_month", exp.day_of_month, got.day_of_month);
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   sender_idle_pct;
    int   recv_idle_pct;

    calendar_checker dates;

    esc_req_if req_ch ();
    esc_rsp_if rsp_ch ();

    epoch_seconds_to_calendar dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Clock
    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Monitor both channels on the rising edge
    always @(posedge clk) begin
        if (rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready)
                dates.check_result('{rsp_ch.second, rsp_ch.minute, rsp_ch.hour,
                                     rsp_ch.weekday, rsp_ch.years_since_1900,
                                     rsp_ch.month_index, rsp_ch.day_of_month});
            if (req_ch.valid && req_ch.ready)
                dates.note_request(req_ch.epoch_seconds);
        end
    end

    // Response side back-pressure, mostly short stalls with an occasional long one
    initial begin: response_sink
        int stall;
        stall = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (stall > 0) begin
                stall--;
                rsp_ch.ready <= 1'b0;
            end
            else if ($urandom_range(99) < recv_idle_pct) begin
                stall = ($urandom_range(9) == 0) ? $urandom_range(10, 150) : $urandom_range(0, 4);
                rsp_ch.ready <= 1'b0;
            end
            else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles with no transaction on either channel
    initial begin: watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Verification failed");
        $finish;
    end

    // Present one request, called and returning at a falling edge
    task automatic send_epoch(input logic [EPOCH_W-1:0] secs);
        int gap;
        if ($urandom_range(99) < sender_idle_pct) begin
            gap = ($urandom_range(7) == 0) ? $urandom_range(20, 130) : $urandom_range(1, 6);
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.epoch_seconds <= secs;
        do @(posedge clk); while (!req_ch.ready);
        @(negedge clk);
    endtask

    // Mix of full-range values, the first days, and instants around midnight
    function automatic logic [EPOCH_W-1:0] random_epoch();
        longint unsigned v;
        case ($urandom_range(3))
            0, 1:    v = $urandom & 32'h7FFF_FFFF;
            2:       v = $urandom_range(0, 3 * 86400);
            default: v = longint'($urandom_range(1, MAX_DAY_INDEX - 1)) * 86400
                         + $urandom_range(0, 3) - 2;
        endcase
        return EPOCH_W'(v);
    endfunction

    // Stimulus
    initial begin: stimulus
        logic [EPOCH_W-1:0] directed[$];
        dates = new();
        sender_idle_pct = 14;
        recv_idle_pct   = 60;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.epoch_seconds = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Field extremes, leap and month edges, year turns, alternating bits
        directed = '{31'd0, 31'd59, 31'd60, 31'd3599, 31'd3600, 31'd86399, 31'd86400,
                     31'd5011199, 31'd5097600, 31'd31535999, 31'd31536000,
                     31'd68169600, 31'd94694399, 31'd94694400, 31'd946684799,
                     31'd951782400, 31'd951868800, 31'd978307199, 31'd978307200,
                     31'd2145916800, 31'h5555_5555, 31'h2AAA_AAAA, 31'h7FFF_FFFF};
        foreach (directed[i])
            send_epoch(directed[i]);

        // Random part in three pacing phases
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 3) begin
                sender_idle_pct = 60;
                recv_idle_pct   = 14;
            end
            else if (n == 2 * RANDOM_ITEMS / 3) begin
                sender_idle_pct = 0;
                recv_idle_pct   = 0;
            end
            send_epoch(random_epoch());
        end
        req_ch.valid <= 1'b0;

        // Drain, then allow for any stray late response
        while (dates.pending_dates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (dates.errors == 0 && dates.pending_dates.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
